>>> sv/fpa_pkg.sv
// Shared types and opcodes for the Q24.8 fixed-point ALU.
// No dependencies; every other file in the block imports this package.
package fpa_pkg;

    localparam int WORD_BITS = 32;

    typedef enum logic [3:0] {
        OP_GT  = 4'd0,
        OP_LT  = 4'd1,
        OP_GE  = 4'd2,
        OP_LE  = 4'd3,
        OP_EQ  = 4'd4,
        OP_NE  = 4'd5,
        OP_ADD = 4'd6,
        OP_SUB = 4'd7,
        OP_MUL = 4'd8,
        OP_DIV = 4'd9,
        OP_INC = 4'd10,
        OP_DEC = 4'd11
    } opcode_t;

    typedef struct packed {
        logic [3:0]                  opcode;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } fpa_cmd_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result;
        logic                        compare_true;
        logic                        divide_by_zero;
    } fpa_res_t;

    // Side data riding alongside the divider cells.
    typedef struct packed {
        logic                 is_div;
        logic                 neg;
        logic                 dz;
        logic                 cmp;
        logic [WORD_BITS-1:0] res;
    } fpa_side_t;

endpackage

>>> sv/fpa_front.sv
// Entry stage: decode, compare, add/sub/inc/dec, multiply, and divider operand setup.
// Depends on fpa_pkg.
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cmd_valid,
    output logic                                          cmd_ready,
    input  fpa_pkg::fpa_cmd_t                             cmd,
    output logic                                          v,
    input  logic                                          nxt_ready,
    output fpa_pkg::fpa_side_t                            side,
    output logic [fpa_pkg::WORD_BITS-1:0]                 divisor,
    output logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0]       num
);
    import fpa_pkg::*;

    localparam int W = WORD_BITS;
    localparam int N = WORD_BITS + FRAC_BITS;

    logic                   v_reg, v_next;
    fpa_side_t              side_reg, side_next;
    logic [W-1:0]           divisor_reg, divisor_next;
    logic [N-1:0]           num_reg, num_next;
    logic signed [2*W-1:0]  prod;
    logic signed [2*W-1:0]  prod_sh;
    logic [W-1:0]           ua, ub;
    logic                   a_lt_b, a_gt_b, a_eq_b;
    logic                   load;

    assign load      = cmd_valid && cmd_ready;
    assign cmd_ready = !v_reg || nxt_ready;
    assign v_next    = load ? 1'b1 : (nxt_ready ? 1'b0 : v_reg);

    assign prod    = cmd.operand_a * cmd.operand_b;
    assign prod_sh = prod >>> FRAC_BITS;
    assign ua      = cmd.operand_a[W-1] ? W'(-cmd.operand_a) : W'(cmd.operand_a);
    assign ub      = cmd.operand_b[W-1] ? W'(-cmd.operand_b) : W'(cmd.operand_b);
    assign a_lt_b  = cmd.operand_a < cmd.operand_b;
    assign a_gt_b  = cmd.operand_b < cmd.operand_a;
    assign a_eq_b  = cmd.operand_a == cmd.operand_b;

    always_comb
    begin
        side_next        = '0;
        side_next.neg    = cmd.operand_a[W-1] ^ cmd.operand_b[W-1];
        divisor_next     = ub;
        num_next         = {ua, {FRAC_BITS{1'b0}}};
        case (opcode_t'(cmd.opcode))
            OP_GT:  side_next.cmp = a_gt_b;
            OP_LT:  side_next.cmp = a_lt_b;
            OP_GE:  side_next.cmp = !a_lt_b;
            OP_LE:  side_next.cmp = !a_gt_b;
            OP_EQ:  side_next.cmp = a_eq_b;
            OP_NE:  side_next.cmp = !a_eq_b;
            OP_ADD: side_next.res = W'(cmd.operand_a + cmd.operand_b);
            OP_SUB: side_next.res = W'(cmd.operand_a - cmd.operand_b);
            OP_MUL: side_next.res = prod_sh[W-1:0];
            OP_DIV:
            begin
                side_next.is_div = 1'b1;
                side_next.dz     = (cmd.operand_b == '0);
            end
            OP_INC: side_next.res = W'(cmd.operand_a + W'(1));
            OP_DEC: side_next.res = W'(cmd.operand_a - W'(1));
            default: side_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            side_reg    <= side_next;
            divisor_reg <= divisor_next;
            num_reg     <= num_next;
        end
    end

    assign v       = v_reg;
    assign side    = side_reg;
    assign divisor = divisor_reg;
    assign num     = num_reg;
endmodule

>>> sv/fpa_cell.sv
// One restoring-division cell: shifts in one dividend bit, retires one quotient bit.
// Depends on fpa_pkg.
module fpa_cell #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    v_in,
    output logic                                    ready_out,
    input  fpa_pkg::fpa_side_t                      side_in,
    input  logic [fpa_pkg::WORD_BITS-1:0]           divisor_in,
    input  logic [fpa_pkg::WORD_BITS-1:0]           rem_in,
    input  logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0] num_in,
    output logic                                    v_out,
    input  logic                                    ready_in,
    output fpa_pkg::fpa_side_t                      side_out,
    output logic [fpa_pkg::WORD_BITS-1:0]           divisor_out,
    output logic [fpa_pkg::WORD_BITS-1:0]           rem_out,
    output logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0] num_out
);
    import fpa_pkg::*;

    localparam int W = WORD_BITS;
    localparam int N = WORD_BITS + FRAC_BITS;

    logic           v_reg, v_next;
    fpa_side_t      side_reg;
    logic [W-1:0]   divisor_reg;
    logic [W-1:0]   rem_reg, rem_next;
    logic [N-1:0]   num_reg, num_next;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           qbit;
    logic           load;

    assign load      = v_in && ready_out;
    assign ready_out = !v_reg || ready_in;
    assign v_next    = load ? 1'b1 : (ready_in ? 1'b0 : v_reg);

    assign trial    = {rem_in, num_in[N-1]};
    assign diff     = trial - {1'b0, divisor_in};
    assign qbit     = trial >= {1'b0, divisor_in};
    assign rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
    assign num_next = {num_in[N-2:0], qbit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            side_reg    <= side_in;
            divisor_reg <= divisor_in;
            rem_reg     <= rem_next;
            num_reg     <= num_next;
        end
    end

    assign v_out       = v_reg;
    assign side_out    = side_reg;
    assign divisor_out = divisor_reg;
    assign rem_out     = rem_reg;
    assign num_out     = num_reg;
endmodule

>>> sv/fpa_back.sv
// Result stage: sign-fix the quotient, pick the result, hold it for the consumer.
// Depends on fpa_pkg.
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    v_in,
    output logic                                    ready_out,
    input  fpa_pkg::fpa_side_t                      side_in,
    input  logic [fpa_pkg::WORD_BITS+FRAC_BITS-1:0] quo_in,
    output logic                                    res_valid,
    input  logic                                    res_stall,
    output fpa_pkg::fpa_res_t                       res
);
    import fpa_pkg::*;

    localparam int W = WORD_BITS;

    logic         res_valid_reg, res_valid_next;
    fpa_res_t     res_reg, res_next;
    logic [W-1:0] q;
    logic         load;

    assign load           = v_in && ready_out;
    assign ready_out      = !res_valid_reg || !res_stall;
    assign res_valid_next = load ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);

    assign q = side_in.neg ? W'(-quo_in[W-1:0]) : quo_in[W-1:0];

    always_comb
    begin
        res_next                = '0;
        res_next.compare_true   = side_in.cmp;
        res_next.divide_by_zero = side_in.dz;
        if (side_in.is_div)
        begin
            res_next.result = side_in.dz ? '0 : q;
        end
        else
        begin
            res_next.result = side_in.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

>>> sv/fixed_point_q24_8_alu_core.sv
// Q24.8 fixed-point ALU: compares, add, sub, inc, dec, multiply and divide on 32-bit words.
// Takes one command beat per cycle while res_stall is low; every beat returns one result
// beat after passing the front stage, the row of division cells (one quotient bit per
// cell) and the result stage. Each stage holds its beat when the next one stalls.
// Depends on fpa_pkg, fpa_front, fpa_cell, fpa_back.
module fixed_point_q24_8_alu_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  fpa_pkg::fpa_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output fpa_pkg::fpa_res_t res
);
    import fpa_pkg::*;

    localparam int W = WORD_BITS;
    localparam int N = WORD_BITS + FRAC_BITS;

    logic         v       [0:N];
    logic         ready   [0:N];
    fpa_side_t    side    [0:N];
    logic [W-1:0] divisor [0:N];
    logic [W-1:0] rem     [0:N];
    logic [N-1:0] num     [0:N];
    logic         cmd_ready;

    assign cmd_stall = !cmd_ready;
    assign rem[0]    = '0;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .v         (v[0]),
        .nxt_ready (ready[0]),
        .side      (side[0]),
        .divisor   (divisor[0]),
        .num       (num[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fpa_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .v_in        (v[i]),
            .ready_out   (ready[i]),
            .side_in     (side[i]),
            .divisor_in  (divisor[i]),
            .rem_in      (rem[i]),
            .num_in      (num[i]),
            .v_out       (v[i+1]),
            .ready_in    (ready[i+1]),
            .side_out    (side[i+1]),
            .divisor_out (divisor[i+1]),
            .rem_out     (rem[i+1]),
            .num_out     (num[i+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .v_in      (v[N]),
        .ready_out (ready[N]),
        .side_in   (side[N]),
        .quo_in    (num[N]),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    a_cmp_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.compare_true |-> res.result == '0)
        else $error("compare beat carries a nonzero result");

    a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.divide_by_zero |-> res.result == '0 && !res.compare_true)
        else $error("divide-by-zero beat carries data");

    a_last_cell_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v[N] && !res_valid |-> ready[N])
        else $error("empty output stage refused the last cell");
endmodule
